@@ design/sbog_pkg.sv @@
// Shared types and constants of the spatial bin observation gate.
`default_nettype none

package sbog_pkg;

  // Field widths of the item and result words
  localparam int CMD_W      = 2;
  localparam int POS_W      = 13;
  localparam int ADD_W      = 16;
  localparam int DIM_W      = 11;
  localparam int COUNT_W    = 16;
  localparam int BIN_W      = 10;
  localparam int DIST_W     = 26;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Internal arithmetic: positions and grid values stay below 2^VAL_W
  localparam int VAL_W      = 13;
  localparam int DSQ_W      = 2 * VAL_W + 1;

  // Bitmap word organisation
  localparam int MEM_W      = 64;
  localparam int BIT_W      = 6;

  // Snap pipeline depth and its wait counter
  localparam int SNAP_LAT   = 6;
  localparam int WAIT_W     = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = DIM_W'(480);
  localparam logic [COUNT_W-1:0] RST_BASE_MAX     = COUNT_W'(30);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MAX     = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_RAISE   = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SNAP,
    ST_INDEX,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/sbog_snap.sv @@
// Per-axis snap pipeline: nearest grid centre, its index, grid size and squared offset.
`default_nettype none

module sbog_snap import sbog_pkg::*; #(
  parameter int GRID_STEP     = 16,
  parameter int MAX_FRAME_DIM = 1024,
  localparam int GRID_SIDE    = (MAX_FRAME_DIM + GRID_STEP - 1) / GRID_STEP,
  localparam int IW           = $clog2(GRID_SIDE + 1)
) (
  input  wire logic                    clk,
  input  wire logic signed [POS_W-1:0] pos,
  input  wire logic [DIM_W-1:0]        dim,
  output logic [IW-1:0]                idx,
  output logic [IW-1:0]                cells,
  output logic [VAL_W-1:0]             coord,
  output logic [DSQ_W-1:0]             dsq
);

  // floor(v / GRID_STEP) == (v * RECIP) >> SH for every v below 2^VAL_W
  localparam int SW    = $clog2(GRID_STEP);
  localparam int SH    = VAL_W + SW;
  localparam int RECIP = ((1 << SH) + GRID_STEP - 1) / GRID_STEP;
  localparam int RW    = VAL_W + 2;
  localparam int PRD_W = VAL_W + RW;

  logic [VAL_W-1:0]        dim_c;
  logic [VAL_W-1:0]        s1_p;
  logic [VAL_W-1:0]        s1_d;
  logic [PRD_W-1:0]        prod_p;
  logic [PRD_W-1:0]        prod_n;
  logic [VAL_W-1:0]        s2_q0;
  logic [VAL_W-1:0]        s2_n;
  logic [VAL_W-1:0]        s3_rem;
  logic                    round_up;
  logic [VAL_W-1:0]        q1;
  logic [VAL_W-1:0]        q_lim;
  logic [VAL_W-1:0]        s4_q;
  logic [VAL_W-1:0]        coord_c;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W-1:0]        s5_coord;
  logic signed [VAL_W:0]   s5_d;
  logic signed [2*VAL_W+1:0] sq;
  logic [DSQ_W-1:0]        s6_dsq;

  // clamp frame size: zero counts as one, oversize counts as the maximum
  always_comb begin
    if (dim == '0) begin
      dim_c = VAL_W'(1);
    end else if (VAL_W'(dim) > VAL_W'(MAX_FRAME_DIM)) begin
      dim_c = VAL_W'(MAX_FRAME_DIM);
    end else begin
      dim_c = VAL_W'(dim);
    end
  end

  assign prod_p   = PRD_W'(s1_p) * PRD_W'(RECIP);
  assign prod_n   = PRD_W'(s1_d) * PRD_W'(RECIP);
  assign round_up = {s3_rem, 1'b0} > (VAL_W + 1)'(GRID_STEP);
  assign q1       = s2_q0 + VAL_W'(round_up);
  assign q_lim    = s2_n - VAL_W'(1);
  assign coord_c  = VAL_W'(s4_q * VAL_W'(GRID_STEP));
  assign diff     = $signed({pos[POS_W-1], pos}) - $signed({1'b0, coord_c});
  assign sq       = s5_d * s5_d;

  always_ff @(posedge clk) begin
    // negative and zero positions snap to the first centre
    s1_p     <= (!pos[POS_W-1] && pos != '0) ? {1'b0, pos[POS_W-2:0]} : '0;
    s1_d     <= dim_c + VAL_W'(GRID_STEP - 1);
    s2_q0    <= VAL_W'(prod_p >> SH);
    s2_n     <= VAL_W'(prod_n >> SH);
    s3_rem   <= s1_p - VAL_W'(s2_q0 * VAL_W'(GRID_STEP));
    s4_q     <= (q1 > q_lim) ? q_lim : q1;
    s5_coord <= coord_c;
    s5_d     <= diff;
    s6_dsq   <= sq[DSQ_W-1:0];
  end

  assign idx   = s4_q[IW-1:0];
  assign cells = s2_n[IW-1:0];
  assign coord = s5_coord;
  assign dsq   = s6_dsq;

endmodule

`default_nettype wire

@@ design/sbog_bitmap.sv @@
// Bin bitmap memory: one write port, one read port with registered data.
`default_nettype none

module sbog_bitmap import sbog_pkg::*; #(
  parameter int WORDS = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [MEM_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic [MEM_W-1:0]      rd_data
);

  logic [MEM_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/spatial_bin_observation_gate.sv @@
// Top level of the spatial bin observation gate: sequencer, gate state and result register.
`default_nettype none

// Snaps each image point to the nearest centre of a square grid of pitch GRID_STEP
// (each axis on its own, ties to the lower centre, clamped to the grid set by the
// frame size registers) and gates it as an observation: a point is taken when force_req
// is set, or when no model is built, the count is below the limit and its bin is still
// free in the bin bitmap, which it then marks. Reaching the limit raises build_now and
// the built flag. Command 1 raises the limit by a positive add_count and clears the
// built flag; command 2 restores the base limit and clears count, flag and bitmap.
// Every word, whatever its command, yields exactly one result word carrying the
// nearest centre and its squared distance.
// Sequence: an item passes from acceptance through the snap pipeline, the bin index
// multiply, the bitmap read and the read-modify-write to the result register; the next
// word is taken only in the cycle after that, and an item is retired only while the result
// side keeps up. The bitmap sits in 64-bit words of one synchronous memory, 64 words at
// the default grid, ceil(GRID_SIDE^2 / 64) in general; after reset and after every
// clear command a clearing pass writes zero to each word, one a cycle, during which no
// item is taken. Configuration writes are taken at any time but must only be issued
// while the block is idle.
module spatial_bin_observation_gate import sbog_pkg::*; #(
  parameter int GRID_STEP     = 16,
  parameter int MAX_FRAME_DIM = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  // item channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [CMD_W-1:0]         cmd,
  input  wire logic signed [POS_W-1:0]  img_x,
  input  wire logic signed [POS_W-1:0]  img_y,
  input  wire logic                     force_req,
  input  wire logic signed [ADD_W-1:0]  add_count,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          added,
  output logic                          build_now,
  output logic [BIN_W-1:0]              bin_x,
  output logic [BIN_W-1:0]              bin_y,
  output logic [DIST_W-1:0]             dist_sq,
  output logic [COUNT_W-1:0]            obs_count,
  output logic                          model_built
);

  localparam int GRID_SIDE = (MAX_FRAME_DIM + GRID_STEP - 1) / GRID_STEP;
  localparam int IW        = $clog2(GRID_SIDE + 1);
  localparam int BIN_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int WORDS     = (BIN_DEPTH + MEM_W - 1) / MEM_W;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW        = AW + BIT_W;

  // configuration registers
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [COUNT_W-1:0] base_max_count;

  // gate state
  logic [COUNT_W-1:0] accepted_count;
  logic [COUNT_W-1:0] count_limit;
  logic               built_flag;

  // held item word
  cmd_t                      item_cmd;
  logic signed [POS_W-1:0]   item_x;
  logic signed [POS_W-1:0]   item_y;
  logic                      item_force;
  logic signed [ADD_W-1:0]   item_add;

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [WAIT_W-1:0]  wait_cnt;
  logic [AW-1:0]      clr_addr;
  logic               finish;

  // snap results
  logic [IW-1:0]      x_idx;
  logic [IW-1:0]      y_idx;
  logic [IW-1:0]      x_cells;
  logic [IW-1:0]      y_cells;
  logic [VAL_W-1:0]   x_coord;
  logic [VAL_W-1:0]   y_coord;
  logic [DSQ_W-1:0]   x_dsq;
  logic [DSQ_W-1:0]   y_dsq;
  logic [DSQ_W:0]     dsq_sum;

  // bin index and distance, registered in the index step
  logic [XW-1:0]      lin;
  logic [DIST_W-1:0]  dist_sat;

  // bitmap access
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [MEM_W-1:0]   mem_wr_data;
  logic               mem_rd_en;
  logic [MEM_W-1:0]   mem_rd_data;
  logic [BIT_W-1:0]   bit_sel;
  logic               taken;

  // update logic of the read-modify-write step
  logic               gate_open;
  logic               mark;
  logic               take;
  logic               build;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] limit_next;
  logic               built_next;
  logic [COUNT_W:0]   raised;

  sbog_snap #(
    .GRID_STEP     (GRID_STEP),
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_snap_x (
    .clk   (clk),
    .pos   (item_x),
    .dim   (frame_width),
    .idx   (x_idx),
    .cells (x_cells),
    .coord (x_coord),
    .dsq   (x_dsq)
  );

  sbog_snap #(
    .GRID_STEP     (GRID_STEP),
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_snap_y (
    .clk   (clk),
    .pos   (item_y),
    .dim   (frame_height),
    .idx   (y_idx),
    .cells (y_cells),
    .coord (y_coord),
    .dsq   (y_dsq)
  );

  sbog_bitmap #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (lin[XW-1:BIT_W]),
    .rd_data (mem_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Configuration: always ready, writes beyond the register list are dropped
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= RST_FRAME_WIDTH;
      frame_height   <= RST_FRAME_HEIGHT;
      base_max_count <= RST_BASE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width    <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height   <= cfg_data[DIM_W-1:0];
        REG_BASE_MAX:     base_max_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SNAP;
        end
      end
      ST_SNAP: begin
        if (wait_cnt == WAIT_W'(SNAP_LAT - 1)) begin
          state_next = ST_INDEX;
        end
      end
      ST_INDEX: state_next = ST_READ;
      ST_READ:  state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = (item_cmd == CMD_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    mem_rd_en = 1'b0;
    finish    = 1'b0;
    case (state)
      ST_IDLE: in_ready  = 1'b1;
      ST_READ: mem_rd_en = 1'b1;
      // retire the item once the result register is free or being emptied
      ST_DONE: finish    = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      wait_cnt <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SNAP) begin
        wait_cnt <= wait_cnt + WAIT_W'(1);
      end else begin
        wait_cnt <= '0;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end else begin
        clr_addr <= '0;
      end
    end
  end

  // hold the accepted word for the whole item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd   <= cmd_t'(cmd);
      item_x     <= img_x;
      item_y     <= img_y;
      item_force <= force_req;
      item_add   <= add_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Index step: bin number row-major over the current grid, saturated distance
  // ---------------------------------------------------------------------------
  assign dsq_sum = {1'b0, x_dsq} + {1'b0, y_dsq};

  always_ff @(posedge clk) begin
    if (state == ST_INDEX) begin
      lin      <= XW'(y_idx) * XW'(x_cells) + XW'(x_idx);
      dist_sat <= (dsq_sum > (DSQ_W + 1)'(DIST_MAX)) ? DIST_MAX : dsq_sum[DIST_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Read-modify-write step
  // ---------------------------------------------------------------------------
  assign bit_sel   = lin[BIT_W-1:0];
  assign taken     = mem_rd_data[bit_sel];
  assign gate_open = !built_flag && (accepted_count < count_limit);
  assign raised    = {1'b0, count_limit} + {1'b0, item_add};

  always_comb begin
    mark       = 1'b0;
    take       = 1'b0;
    build      = 1'b0;
    count_next = accepted_count;
    limit_next = count_limit;
    built_next = built_flag;
    case (item_cmd)
      CMD_OBSERVE: begin
        mark = gate_open && !item_force && !taken;
        take = item_force || mark;
        // a saturated count takes the point but raises no build
        if (take && accepted_count != COUNT_MAX) begin
          count_next = accepted_count + COUNT_W'(1);
          if (count_next == count_limit) begin
            built_next = 1'b1;
            build      = 1'b1;
          end
        end
      end
      CMD_RAISE: begin
        if (!item_add[ADD_W-1] && item_add != '0) begin
          limit_next = raised[COUNT_W] ? COUNT_MAX : raised[COUNT_W-1:0];
          built_next = 1'b0;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
        limit_next = base_max_count;
        built_next = 1'b0;
      end
      default: ;
    endcase
  end

  // clearing pass writes zero words; otherwise mark the bin of a new observation
  assign mem_wr_en   = (state == ST_CLEAR) || (finish && mark);
  assign mem_wr_addr = (state == ST_CLEAR) ? clr_addr : lin[XW-1:BIT_W];
  assign mem_wr_data = (state == ST_CLEAR) ? '0 : (mem_rd_data | (MEM_W'(1) << bit_sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_count <= '0;
      count_limit    <= RST_BASE_MAX;
      built_flag     <= 1'b0;
    end else if (finish) begin
      accepted_count <= count_next;
      count_limit    <= limit_next;
      built_flag     <= built_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on retire, drop valid once the word is taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      added       <= take;
      build_now   <= build;
      bin_x       <= x_coord[BIN_W-1:0];
      bin_y       <= y_coord[BIN_W-1:0];
      dist_sq     <= dist_sat;
      obs_count   <= count_next;
      model_built <= built_next;
    end
  end

`ifndef SYNTHESIS
  // the built flag only comes up together with a build result
  assert property (@(posedge clk) disable iff (rst)
    $rose(built_flag) |-> out_valid && build_now)
    else $error("built flag rose without a build result");

  // a build result always comes from an accepted point and leaves the flag set
  assert property (@(posedge clk) disable iff (rst)
    out_valid && build_now |-> added && model_built)
    else $error("build result without accepted point or built flag");

  // a marking write only ever targets a free bin
  assert property (@(posedge clk) disable iff (rst)
    finish && mem_wr_en |-> !taken)
    else $error("bitmap marked a bin that was already taken");

  // a clear command starts the clearing pass from the first word
  assert property (@(posedge clk) disable iff (rst)
    finish && item_cmd == CMD_CLEAR |=> state == ST_CLEAR && clr_addr == '0)
    else $error("clear command did not start a clearing pass");
`endif

endmodule

`default_nettype wire
